// ===== rtl/pnra_pkg.sv =====
// Package: shared constants and codes for the per-node running average alarm.
`timescale 1ns / 1ps

package pnra_pkg;

   localparam int NODES      = 16;
   localparam int COUNT_BITS = 24;

   localparam int NODE_W     = 8;
   localparam int SAMPLE_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam int NODE_IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int DIV_W      = COUNT_BITS + 1;          // count + 1
   localparam int REM_W      = DIV_W + 1;               // shifted partial remainder
   localparam int ACC_W      = SAMPLE_W + DIV_W;        // mean * count + sample
   localparam int ITER_W     = $clog2(ACC_W + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [NODE_W:0]       NODES_EXT = (NODE_W + 1)'(NODES);

   localparam logic signed [SAMPLE_W-1:0] HOT_RESET  = 16'sd7680;   // 30.0 degrees
   localparam logic signed [SAMPLE_W-1:0] COLD_RESET = 16'sd3840;   // 15.0 degrees

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HOT_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLD_LIMIT = 1'd1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_NORMAL  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HOT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_COLD    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd3;

endpackage

// ===== rtl/per_node_running_average_alarm.sv =====
// Top level: per-node cumulative mean with hot and cold alarm, shared-divider datapath.
`timescale 1ns / 1ps
//
// Usage
//   req_ channel: one beat carries a node number and a signed Q8.8 sample.
//   rsp_ channel: one beat per request with the node, the new mean of that
//   node and a status (normal, hot, cold, invalid node).
//   csr_ port: hot_limit (index 0) and cold_limit (index 1), to be written by
//   the user only while the block is idle, not enforced; other indexes are dropped.
// Sequence
//   For a valid node the tables are read at the request beat, then come a
//   multiply step, a step to add the sample and take its magnitude, 41 steps
//   of the radix-2 restoring divider (one quotient bit per cycle over the
//   41-bit accumulator) and a finish step, after which rsp_valid rises.
//   An invalid node goes straight to the finish step and leaves the tables alone.
//   req_ready is low while an item is in work: a new request is taken only
//   once the previous one has left the finish step.
// Reset
//   Synchronous, active high: all node means and counts read as zero (per
//   node valid bits), limits go to 30.0 and 15.0 degrees, rsp_valid drops.
// Back-pressure
//   The result sits in an output register; a new request is taken while it
//   waits. The finish step stalls only if the previous result is still held.
module per_node_running_average_alarm
   import pnra_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // request
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [NODE_W-1:0]           req_node_number,
   input  logic signed [SAMPLE_W-1:0]  req_sample_value,
   // response
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [NODE_W-1:0]           rsp_node_echo,
   output logic signed [SAMPLE_W-1:0]  rsp_mean_value,
   output logic [STATUS_W-1:0]         rsp_status_code,
   // configuration
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   // node tables: plain arrays, zero-on-reset via valid bits
   logic signed [SAMPLE_W-1:0]  mean_mem [NODES];
   logic [COUNT_BITS-1:0]       cnt_mem  [NODES];
   logic [NODES-1:0]            vld_ff, vld_in;

   logic [2:0]                  state_ff, state_in;
   logic [NODE_W-1:0]           node_ff;
   logic signed [SAMPLE_W-1:0]  sample_ff;
   logic                        bad_ff;
   logic                        hit_ff;          // valid bit of the read entry
   logic signed [SAMPLE_W-1:0]  mean_rd_ff;
   logic [COUNT_BITS-1:0]       cnt_rd_ff;
   logic signed [ACC_W-1:0]     prod_ff;
   logic [COUNT_BITS-1:0]       cnt_ff;
   logic [ACC_W-1:0]            mag_ff;          // dividend, becomes quotient
   logic [DIV_W-1:0]            div_ff;
   logic [DIV_W-1:0]            rem_ff;
   logic                        neg_ff;
   logic [ITER_W-1:0]           iter_ff;

   logic signed [SAMPLE_W-1:0]  hot_ff, cold_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]           rsp_node_ff;
   logic signed [SAMPLE_W-1:0]  rsp_mean_ff;
   logic [STATUS_W-1:0]         rsp_status_ff;

   logic                        req_fire;
   logic                        fin_fire;
   logic [NODE_IDX_W-1:0]       rd_idx, wr_idx;
   logic signed [SAMPLE_W-1:0]  cur_mean;
   logic [COUNT_BITS-1:0]       cur_cnt;
   logic signed [ACC_W-1:0]     prod_w;
   logic signed [ACC_W-1:0]     acc_w;
   logic [REM_W-1:0]            rem_shift;
   logic [REM_W-1:0]            rem_diff;
   logic                        q_bit;
   logic signed [SAMPLE_W-1:0]  q_mean;
   logic [STATUS_W-1:0]         q_status;
   logic [COUNT_BITS-1:0]       cnt_next;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign fin_fire  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   assign rd_idx = req_node_number[NODE_IDX_W-1:0];
   assign wr_idx = node_ff[NODE_IDX_W-1:0];

   // multiply: entry that was never written counts as zero
   assign cur_mean = hit_ff ? mean_rd_ff : '0;
   assign cur_cnt  = hit_ff ? cnt_rd_ff  : '0;
   assign prod_w   = cur_mean * $signed({1'b0, cur_cnt});
   assign acc_w    = prod_ff + ACC_W'(sample_ff);

   // one restoring divider step
   assign rem_shift = {rem_ff, mag_ff[ACC_W-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign q_bit     = (rem_shift >= {1'b0, div_ff});

   // sign, saturation guard and status of the quotient, saturating next count
   always_comb begin
      if (!neg_ff && (mag_ff > ACC_W'(32767))) begin
         q_mean = 16'sh7FFF;
      end else if (neg_ff && (mag_ff > ACC_W'(32768))) begin
         q_mean = 16'sh8000;
      end else if (neg_ff) begin
         q_mean = $signed(16'(~mag_ff[SAMPLE_W-1:0] + 16'd1));
      end else begin
         q_mean = $signed(mag_ff[SAMPLE_W-1:0]);
      end

      if (bad_ff) begin
         q_status = STATUS_INVALID;
      end else if (q_mean > hot_ff) begin
         q_status = STATUS_HOT;
      end else if (q_mean < cold_ff) begin
         q_status = STATUS_COLD;
      end else begin
         q_status = STATUS_NORMAL;
      end

      cnt_next = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = ({1'b0, req_node_number} < NODES_EXT) ? S_READ : S_FIN;
            end
         end
         S_READ: state_in = S_MUL;
         S_MUL:  state_in = S_DIV;
         S_DIV: begin
            if (iter_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (fin_fire && !bad_ff) begin
         vld_in[wr_idx] = 1'b1;
      end
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hot_ff       <= HOT_RESET;
         cold_ff      <= COLD_RESET;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_HOT_LIMIT:  hot_ff  <= $signed(csr_wdata);
               REG_COLD_LIMIT: cold_ff <= $signed(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   // table memory: registered read at the request beat, write at finish
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mean_rd_ff <= mean_mem[rd_idx];
         cnt_rd_ff  <= cnt_mem[rd_idx];
      end
      if (fin_fire && !bad_ff) begin
         mean_mem[wr_idx] <= q_mean;
         cnt_mem[wr_idx]  <= cnt_next;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         node_ff   <= req_node_number;
         sample_ff <= req_sample_value;
         bad_ff    <= !({1'b0, req_node_number} < NODES_EXT);
         hit_ff    <= vld_ff[rd_idx];
      end
      case (state_ff)
         S_READ: begin
            prod_ff <= prod_w;
            cnt_ff  <= cur_cnt;
         end
         S_MUL: begin
            neg_ff  <= acc_w[ACC_W-1];
            mag_ff  <= acc_w[ACC_W-1] ? ACC_W'(-acc_w) : ACC_W'(acc_w);
            div_ff  <= {1'b0, cnt_ff} + 1'b1;
            rem_ff  <= '0;
            iter_ff <= ITER_W'(ACC_W - 1);
         end
         S_DIV: begin
            rem_ff  <= q_bit ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            mag_ff  <= {mag_ff[ACC_W-2:0], q_bit};
            iter_ff <= iter_ff - 1'b1;
         end
         default: ;
      endcase
      if (fin_fire) begin
         rsp_node_ff   <= node_ff;
         rsp_mean_ff   <= bad_ff ? '0 : q_mean;
         rsp_status_ff <= q_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_echo   = rsp_node_ff;
   assign rsp_mean_value  = rsp_mean_ff;
   assign rsp_status_code = rsp_status_ff;

endmodule

// ===== rtl/pnra_checker.sv =====
// Checker: port-level assertions for the running average alarm, bound to the top level.
`timescale 1ns / 1ps

module pnra_checker
   import pnra_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [NODE_W-1:0]           rsp_node_echo,
   input logic signed [SAMPLE_W-1:0]  rsp_mean_value,
   input logic [STATUS_W-1:0]         rsp_status_code
);

   // held response beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_node_echo)
         && $stable(rsp_mean_value) && $stable(rsp_status_code))
      else $error("response beat changed while stalled");

   // busy after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // invalid node status matches the node range, both ways
   a_bad_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ({1'b0, rsp_node_echo} >= NODES_EXT) |-> rsp_status_code == STATUS_INVALID)
      else $error("out-of-range node without invalid status");

   a_bad_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status_code == STATUS_INVALID)
         |-> ({1'b0, rsp_node_echo} >= NODES_EXT) && (rsp_mean_value == '0))
      else $error("invalid status on a good node or with a non-zero mean");

endmodule

bind per_node_running_average_alarm pnra_checker u_pnra_checker (.*);

// ===== tb/per_node_running_average_alarm_tb.sv =====
// Testbench for the per-node running average alarm: self-checking, directed then random.
`timescale 1ns / 1ps

module per_node_running_average_alarm_tb;
   import pnra_pkg::*;

   // One expected response beat.
   typedef struct packed {
      logic [NODE_W-1:0]          node;
      logic signed [SAMPLE_W-1:0] mean;
      logic [STATUS_W-1:0]        status;
   } node_report_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [NODE_W-1:0]           req_node_number;
   logic signed [SAMPLE_W-1:0]  req_sample_value;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [NODE_W-1:0]           rsp_node_echo;
   logic signed [SAMPLE_W-1:0]  rsp_mean_value;
   logic [STATUS_W-1:0]         rsp_status_code;
   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   // Shadow copy of the block's state and limits, advanced on every request beat.
   logic signed [SAMPLE_W-1:0]  mean_shadow  [NODES];
   logic [COUNT_BITS-1:0]       count_shadow [NODES];
   logic signed [SAMPLE_W-1:0]  hot_shadow;
   logic signed [SAMPLE_W-1:0]  cold_shadow;

   node_report_type report_q[$];  // responses still owed by the block, oldest first
   int              mismatch_count;

   // Idling controls: source = request side, sink = response side.
   bit           source_idle;
   bit           sink_idle;
   int           sink_hold_cycles;  // one-off long hold-off requested of the sink

   per_node_running_average_alarm i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_node_number  (req_node_number),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_node_echo    (rsp_node_echo),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_status_code  (rsp_status_code),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous cap: the slowest legal run is well under a fifth of this.
   initial begin
      #10_000_000;
      $display("per_node_running_average_alarm test failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Predictor: cumulative mean per node, truncating division, count saturates.
   // Updates the shadow tables and returns the response the block owes.
   // --------------------------------------------------------------------------
   function automatic node_report_type update_node_mean(
                                        input logic [NODE_W-1:0] node,
                                        input logic signed [SAMPLE_W-1:0] sample);
      node_report_type rep;
      logic [COUNT_BITS-1:0] cnt;
      longint acc;
      longint divisor;
      longint quot;
      int idx;
      rep.node = node;
      if (node >= NODES) begin
         // out-of-range node: zero mean, tables untouched
         rep.mean   = '0;
         rep.status = STATUS_INVALID;
         return rep;
      end
      idx     = int'(node);
      cnt     = count_shadow[idx];
      acc     = longint'(mean_shadow[idx]) * longint'(cnt) + longint'(sample);
      divisor = longint'(cnt) + 1;
      quot    = acc / divisor;          // SV signed division truncates toward zero
      if (quot > 32767)  quot = 32767;
      if (quot < -32768) quot = -32768;
      mean_shadow[idx] = quot[SAMPLE_W-1:0];
      if (cnt != COUNT_MAX)
         count_shadow[idx] = cnt + 1'b1;
      rep.mean = quot[SAMPLE_W-1:0];
      // hot wins when the limits overlap
      if (quot > longint'(hot_shadow))
         rep.status = STATUS_HOT;
      else if (quot < longint'(cold_shadow))
         rep.status = STATUS_COLD;
      else
         rep.status = STATUS_NORMAL;
      return rep;
   endfunction

   // --------------------------------------------------------------------------
   // Request driver. Called just after a rising edge; returns on the edge that
   // takes the beat, leaving valid high so a back-to-back beat needs no toggle.
   // --------------------------------------------------------------------------
   task automatic send_reading(input logic [NODE_W-1:0] node,
                               input logic signed [SAMPLE_W-1:0] sample);
      int gap;
      gap = source_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_node_number  <= node;
      req_sample_value <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      report_q.push_back(update_node_mean(node, sample));
   endtask

   // Sender pauses until every owed response has been taken.
   task automatic wait_all_reports;
      req_valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
   endtask

   // Both limits in consecutive cycles; only ever called with the block idle.
   task automatic set_limits(input logic signed [SAMPLE_W-1:0] hot,
                             input logic signed [SAMPLE_W-1:0] cold);
      csr_we    <= 1'b1;
      csr_index <= REG_HOT_LIMIT;
      csr_wdata <= hot;
      @(posedge clock);
      csr_index <= REG_COLD_LIMIT;
      csr_wdata <= cold;
      @(posedge clock);
      csr_we      <= 1'b0;
      hot_shadow  = hot;
      cold_shadow = cold;
   endtask

   // --------------------------------------------------------------------------
   // Response sink: random stall per beat, plus a one-off long hold-off.
   // --------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end
         stall = sink_idle ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic report_mismatch(input string field,
                                  input logic signed [31:0] expected,
                                  input logic signed [31:0] actual);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
      mismatch_count++;
   endtask

   // Response checker: every accepted beat against the oldest owed response.
   always @(posedge clock) begin
      node_report_type owed;
      if (!reset && rsp_valid && rsp_ready) begin
         if (report_q.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual node %0d mean %0d",
                     $time, rsp_node_echo, rsp_mean_value);
            mismatch_count++;
         end else begin
            owed = report_q.pop_front();
            if (rsp_node_echo !== owed.node)
               report_mismatch("node_echo", owed.node, rsp_node_echo);
            if (rsp_mean_value !== owed.mean)
               report_mismatch("mean_value", owed.mean, rsp_mean_value);
            if (rsp_status_code !== owed.status)
               report_mismatch("status_code", owed.status, rsp_status_code);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Directed tests
   // --------------------------------------------------------------------------

   // Reset limits (30 / 15 degrees): both boundaries, sample extremes, first nodes.
   task automatic test_reset_limits;
      send_reading(8'd2, 16'sd7681);     // just above hot
      send_reading(8'd5, 16'sd7680);     // on hot: normal
      send_reading(8'd3, 16'sd3840);     // on cold: normal
      send_reading(8'd4, 16'sd3839);     // just below cold
      send_reading(8'd0, 16'sd0);
      send_reading(8'd0, 16'sd32767);    // (0 + 32767) / 2
      send_reading(8'd1, -16'sd32768);
      send_reading(8'd15, 16'sd32767);   // top node
      send_reading(8'd15, -16'sd32768);  // -1 / 2 truncates to zero
   endtask

   // Node numbers at and beyond the table size.
   task automatic test_invalid_nodes;
      send_reading(8'd16, 16'sd1000);
      send_reading(8'd255, -16'sd1);
      send_reading(8'd128, 16'sd32767);
   endtask

   // Truncation toward zero on both signs.
   task automatic test_truncation;
      send_reading(8'd6, -16'sd1);
      send_reading(8'd6, 16'sd0);        // -1 / 2 -> 0
      send_reading(8'd6, -16'sd3);       // -3 / 3 -> -1
      send_reading(8'd7, 16'sd3);
      send_reading(8'd7, 16'sd0);        // 3 / 2 -> 1
      send_reading(8'd7, 16'sd0);        // 2 / 3 -> 0
   endtask

   // hot limit below cold limit: a mean in between reports hot.
   task automatic test_overlapping_limits;
      wait_all_reports();
      set_limits(16'sd0, 16'sd100);
      send_reading(8'd8, 16'sd50);
      send_reading(8'd9, -16'sd32768);
   endtask

   // --------------------------------------------------------------------------
   // Random phase: per-node temperature streams around a drawn bias, mixed with
   // full-range samples, extremes and out-of-range nodes.
   // --------------------------------------------------------------------------
   task automatic test_random_streams(input int beats,
                                      input logic signed [SAMPLE_W-1:0] hot,
                                      input logic signed [SAMPLE_W-1:0] cold);
      int bias [NODES];
      int pick;
      int value;
      logic [NODE_W-1:0] node;
      wait_all_reports();
      set_limits(hot, cold);
      // bias from -5 to +45 degrees per node
      foreach (bias[i]) bias[i] = int'($urandom_range(0, 12800)) - 1280;
      for (int n = 0; n < beats; n++) begin
         if (n % 64 == 0) begin
            // roughly one stretch in four runs flat out on each side
            source_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 85)
            node = NODE_W'($urandom_range(0, NODES - 1));
         else if (pick < 95)
            node = NODE_W'($urandom_range(NODES, 255));
         else
            node = NODE_W'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 70)
            value = bias[int'(node) % NODES] + int'($urandom_range(0, 1024)) - 512;
         else if (pick < 90)
            value = int'($signed(16'($urandom)));
         else
            case ($urandom_range(0, 3))
               0: value = 32767;
               1: value = -32768;
               2: value = 0;
               default: value = -1;
            endcase
         send_reading(node, SAMPLE_W'(value));
      end
   endtask

   // Sink holds off long enough for the result register and the datapath to
   // fill, so req_ready must drop while the source keeps offering beats.
   task automatic test_backlog;
      wait_all_reports();
      source_idle      = 1'b0;
      sink_idle        = 1'b0;
      sink_hold_cycles = 400;
      for (int n = 0; n < 10; n++)
         send_reading(NODE_W'($urandom_range(0, NODES - 1)), SAMPLE_W'($urandom));
      wait_all_reports();
   endtask

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------
   initial begin
      logic signed [SAMPLE_W-1:0] lim_a;
      logic signed [SAMPLE_W-1:0] lim_b;
      mismatch_count   = 0;
      sink_hold_cycles = 0;
      source_idle      = 1'b1;
      sink_idle        = 1'b1;
      hot_shadow       = HOT_RESET;
      cold_shadow      = COLD_RESET;
      foreach (mean_shadow[i]) begin
         mean_shadow[i]  = '0;
         count_shadow[i] = '0;
      end
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_node_number  <= '0;
      req_sample_value <= '0;
      csr_we           <= 1'b0;
      csr_index        <= REG_HOT_LIMIT;
      csr_wdata        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_limits();
      test_invalid_nodes();
      test_truncation();
      test_overlapping_limits();

      // Saturated count is out of reach: 2^24 beats per node would far exceed
      // any sensible run length.
      test_random_streams(340, HOT_RESET, COLD_RESET);
      test_backlog();
      test_random_streams(340, 16'sh7FFF, 16'sh8000);   // never alarms
      test_random_streams(340, 16'sh8000, 16'sh7FFF);   // nearly always hot
      lim_a = SAMPLE_W'($urandom);
      lim_b = SAMPLE_W'($urandom);
      test_random_streams(340, lim_a, lim_b);
      // realistic window: hot 20..35 degrees, cold 5..20 degrees
      lim_a = SAMPLE_W'($urandom_range(5120, 8960));
      lim_b = SAMPLE_W'($urandom_range(1280, 5120));
      test_random_streams(340, lim_a, lim_b);

      wait_all_reports();
      // let any stray beat surface before the verdict
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && report_q.size() == 0)
         $display("per_node_running_average_alarm test passed");
      else
         $display("per_node_running_average_alarm test failed");
      $finish;
   end

endmodule
